/* src/oriented_gradient_integral_histogram_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the oriented gradient integral histogram core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ORIENTED_GRADIENT_INTEGRAL_HISTOGRAM_CORE_MACROS_SVH
`define ORIENTED_GRADIENT_INTEGRAL_HISTOGRAM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OGIH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogih assertion failed");
`define OGIH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogih assertion failed");
`else
`define OGIH_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define OGIH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/ogih_pkg.sv */
// ---------------------------------------------------------------------------
// ogih_pkg
// Shared types, widths and the orientation boundary tangents.
// ---------------------------------------------------------------------------
package ogih_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int D_W    = 9;
    localparam int SUM_W  = 23;
    localparam int INT_W  = 33;
    localparam int MAG_W  = 13;
    localparam int BIN_W  = 4;
    localparam int TAN_W  = 19;
    localparam int OUT_BINS = 9;
    localparam int SQ_W   = 26;
    localparam int SQ_STEPS = 13;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Tangents of the bin boundaries below 90 degrees, 16 fraction bits,
    // grouped by bin count.
    localparam logic [TAN_W-1:0] TAN_TABLE [20] = '{
        19'd65536,
        19'd37837,
        19'd27146, 19'd158218,
        19'd21294, 19'd90203,
        19'd17560, 19'd65536, 19'd244584,
        19'd14958, 19'd52263, 19'd136087,
        19'd13036, 19'd43790, 19'd98082, 19'd329472,
        19'd11556, 19'd37837, 19'd78103, 19'd180059
    };
    localparam logic [4:0] TAN_OFFSET [10] = '{
        5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd4, 5'd6, 5'd9, 5'd12, 5'd16
    };

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [TAN_W-1:0] tan_of(input int nb, input logic [3:0] i);
        logic [4:0] idx;
        idx = TAN_OFFSET[nb] + {1'b0, i};
        if (idx > 5'd19) begin
            return '0;
        end
        return TAN_TABLE[idx];
    endfunction

endpackage

/* src/oriented_gradient_integral_histogram_core.sv */
// ---------------------------------------------------------------------------
// oriented_gradient_integral_histogram_core
// Streaming 9-bin oriented gradient integral histogram of a gray image.
// ---------------------------------------------------------------------------
// Pixels enter row by row on i_pixel with i_pixel_valid / o_pixel_stall.
// Each request produces the integral histogram of the row above at the same
// column; on the last row it also produces last-row results, flagged by
// o_final_row. o_last_of_run marks the final result of a pixel; row 0
// pixels produce none.
// The front part takes one pixel at a time: it stalls the pixel side while it
// does its serial line-buffer reads and pushes the pixel's queued jobs one
// after another, holding while the queue is full, and accepts the next
// request once idle again. The back part finishes one job before it takes the
// next one, working through a 13-step bit-serial square root and bin search.
// Results sit in an output register (o_result_valid / i_result_stall); a
// stall holds it, the back part finishes the next job meanwhile, and the
// four-entry job queue then throttles the pixel side. Reset clears the
// counters and row sums; a configuration write restarts the image at row 0.
// ---------------------------------------------------------------------------
`include "oriented_gradient_integral_histogram_core_macros.svh"

module oriented_gradient_integral_histogram_core #(
    parameter int NUM_BINS   = 9,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [ogih_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_pixel_valid,
    output logic                       o_pixel_stall,
    input  logic [ogih_pkg::PIX_W-1:0] i_pixel,
    output logic                       o_result_valid,
    input  logic                       i_result_stall,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin0,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin1,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin2,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin3,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin4,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin5,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin6,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin7,
    output logic [ogih_pkg::INT_W-1:0] o_hist_bin8,
    output logic [ogih_pkg::INT_W-1:0] o_magnitude_integral,
    output logic                       o_final_row,
    output logic                       o_last_of_run
);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int HW    = $clog2(MAX_HEIGHT);
    localparam int JOB_W = 2 * ogih_pkg::D_W + AW + 4;

    logic [ogih_pkg::CFG_W-1:0] r_width_cfg, r_height_cfg;
    logic [AW:0] width_eff;
    logic [HW:0] height_eff;
    logic push, pop;
    logic [JOB_W-1:0] job_in, job_out;
    ogih_pkg::t_q_stat q_stat;
    logic [ogih_pkg::OUT_BINS-1:0][ogih_pkg::INT_W-1:0] hist_bins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= 11'd1024;
            r_height_cfg <= 11'd1024;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ogih_pkg::CFG_WIDTH) begin
                r_width_cfg <= i_cfg_data;
            end else begin
                r_height_cfg <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_width_cfg == '0) begin
            width_eff = (AW+1)'(1);
        end else if (32'(r_width_cfg) > 32'(MAX_WIDTH)) begin
            width_eff = (AW+1)'(MAX_WIDTH);
        end else begin
            width_eff = (AW+1)'(r_width_cfg);
        end
        if (r_height_cfg < 11'd2) begin
            height_eff = (HW+1)'(2);
        end else if (32'(r_height_cfg) > 32'(MAX_HEIGHT)) begin
            height_eff = (HW+1)'(MAX_HEIGHT);
        end else begin
            height_eff = (HW+1)'(r_height_cfg);
        end
    end

    ogih_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .HW        (HW),
        .JOB_W     (JOB_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (i_cfg_we),
        .i_width      (width_eff),
        .i_height     (height_eff),
        .i_pixel_valid(i_pixel_valid),
        .o_pixel_stall(o_pixel_stall),
        .i_pixel      (i_pixel),
        .o_push       (push),
        .o_job        (job_in),
        .i_full       (q_stat.full)
    );

    ogih_queue #(
        .W    (JOB_W),
        .DEPTH(4)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (job_in),
        .i_pop  (pop),
        .o_data (job_out),
        .o_stat (q_stat)
    );

    ogih_back #(
        .NUM_BINS (NUM_BINS),
        .MAX_WIDTH(MAX_WIDTH),
        .AW       (AW),
        .JOB_W    (JOB_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_restart(i_cfg_we),
        .i_job    (job_out),
        .i_empty  (q_stat.empty),
        .o_pop    (pop),
        .o_valid  (o_result_valid),
        .i_stall  (i_result_stall),
        .o_bins   (hist_bins),
        .o_mag    (o_magnitude_integral),
        .o_final  (o_final_row),
        .o_last   (o_last_of_run)
    );

    assign o_hist_bin0 = hist_bins[0];
    assign o_hist_bin1 = hist_bins[1];
    assign o_hist_bin2 = hist_bins[2];
    assign o_hist_bin3 = hist_bins[3];
    assign o_hist_bin4 = hist_bins[4];
    assign o_hist_bin5 = hist_bins[5];
    assign o_hist_bin6 = hist_bins[6];
    assign o_hist_bin7 = hist_bins[7];
    assign o_hist_bin8 = hist_bins[8];

    `OGIH_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, push, !q_stat.full)
    `OGIH_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, pop, !q_stat.empty)
    `OGIH_ASSERT_NEXT(a_busy_after_pixel, i_clk, i_rst_n, i_pixel_valid && !o_pixel_stall, o_pixel_stall)

endmodule

/* src/ogih_queue.sv */
// ---------------------------------------------------------------------------
// ogih_queue
// Small FIFO of gradient jobs between the front and the back part.
// ---------------------------------------------------------------------------
module ogih_queue #(
    parameter int W     = 30,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output ogih_pkg::t_q_stat o_stat
);
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

/* src/ogih_front.sv */
// ---------------------------------------------------------------------------
// ogih_front
// Accepts pixels, keeps the two pixel line buffers and turns each pixel
// into zero to three gradient jobs.
// ---------------------------------------------------------------------------
module ogih_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int AW         = 10,
    parameter int HW         = 10,
    parameter int JOB_W      = 2 * ogih_pkg::D_W + AW + 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic [AW:0]                i_width,
    input  logic [HW:0]                i_height,
    input  logic                       i_pixel_valid,
    output logic                       o_pixel_stall,
    input  logic [ogih_pkg::PIX_W-1:0] i_pixel,
    output logic                       o_push,
    output logic [JOB_W-1:0]           o_job,
    input  logic                       i_full
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_READ = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [ogih_pkg::PIX_W-1:0] mem_n [MAX_WIDTH];
    logic [ogih_pkg::PIX_W-1:0] mem_o [MAX_WIDTH];

    logic [1:0]    r_state, n_state;
    logic [2:0]    r_step;
    logic [AW-1:0] r_col, r_c;
    logic [HW-1:0] r_row;
    logic [ogih_pkg::PIX_W-1:0] r_p, r_nrd, r_ord;
    logic [ogih_pkg::PIX_W-1:0] r_ns [4];
    logic [ogih_pkg::PIX_W-1:0] r_os [2];
    logic r_rowz, r_row1, r_lastrow, r_c0, r_c1, r_cend;
    logic [2:0] r_jm;

    logic accept, cend, lastrow;
    logic [AW-1:0] addr_n, addr_o;
    logic signed [ogih_pkg::D_W-1:0] dx0, dy0, dx1, dy1, dx2, dy2;
    logic [ogih_pkg::PIX_W-1:0] lv, rv, pv, l1, l2;
    logic [JOB_W-1:0] job0, job1, job2;

    function automatic logic signed [ogih_pkg::D_W-1:0] diff(
        input logic [ogih_pkg::PIX_W-1:0] a, input logic [ogih_pkg::PIX_W-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    assign accept        = i_pixel_valid && !o_pixel_stall;
    assign o_pixel_stall = (r_state != F_IDLE);
    assign cend    = ({1'b0, r_col} + 1'b1 == i_width);
    assign lastrow = ({1'b0, r_row} == i_height - 1'b1);

    always_comb begin
        unique case (r_step)
            3'd0:    addr_n = r_c;
            3'd1:    addr_n = r_c + 1'b1;
            3'd2:    addr_n = r_c - 1'b1;
            default: addr_n = r_c - 2'd2;
        endcase
        addr_o = (r_step == 3'd1) ? r_c - 1'b1 : r_c;
    end

    // Line buffers: registered reads, written once the reads are done.
    always_ff @(posedge i_clk) begin
        r_nrd <= mem_n[addr_n];
        r_ord <= mem_o[addr_o];
        if (r_state == F_READ && r_step == 3'd4) begin
            mem_n[r_c] <= r_p;
            if (!r_rowz) begin
                mem_o[r_c] <= r_ns[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_READ && r_step != 3'd0) begin
            r_ns[r_step[1:0] - 2'd1] <= r_nrd;
            if (r_step < 3'd3) begin
                r_os[r_step[0] ^ 1'b1] <= r_ord;
            end
        end
        if (accept) begin
            r_p       <= i_pixel;
            r_c       <= r_col;
            r_rowz    <= (r_row == '0);
            r_row1    <= (r_row == HW'(1));
            r_lastrow <= lastrow;
            r_c0      <= (r_col == '0);
            r_c1      <= (r_col == AW'(1));
            r_cend    <= cend;
        end
    end

    // Gradient inputs of the row above, then of the last row.
    always_comb begin
        lv  = r_c0 ? r_ns[0] : r_os[1];
        rv  = r_cend ? r_ns[0] : r_ns[1];
        pv  = r_row1 ? r_ns[0] : r_os[0];
        l1  = r_c1 ? r_ns[2] : r_ns[3];
        l2  = r_c0 ? r_p : r_ns[2];
        dx0 = diff(rv, lv);
        dy0 = diff(r_p, pv);
        dx1 = diff(r_p, l1);
        dy1 = diff(r_ns[2], r_os[1]);
        dx2 = diff(r_p, l2);
        dy2 = diff(r_p, r_ns[0]);
        job0 = {dx0, dy0, 1'b0, r_row1, r_c, 1'b0,
                !(r_lastrow && (!r_c0 || r_cend))};
        job1 = {dx1, dy1, 1'b1, 1'b0, r_c - 1'b1, 1'b1, !r_cend};
        job2 = {dx2, dy2, 1'b1, 1'b0, r_c, 1'b1, 1'b1};
        if (r_jm[0]) begin
            o_job = job0;
        end else if (r_jm[1]) begin
            o_job = job1;
        end else begin
            o_job = job2;
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_READ;
            end
            F_READ: begin
                if (r_step == 3'd4) n_state = r_rowz ? F_IDLE : F_PUSH;
            end
            F_PUSH: begin
                if (o_push && (r_jm & (r_jm - 1'b1)) == 3'd0) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_jm    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_READ) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (r_state == F_READ && r_step == 3'd4) begin
                r_jm <= {r_lastrow && r_cend, r_lastrow && !r_c0, 1'b1};
            end else if (o_push) begin
                r_jm <= r_jm & (r_jm - 1'b1);
            end
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (cend) begin
                    r_col <= '0;
                    r_row <= lastrow ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

/* src/ogih_back.sv */
// ---------------------------------------------------------------------------
// ogih_back
// Per job: bit-serial square root of the gradient energy, sequential bin
// search, row sums and the integral line update, then the result register.
// ---------------------------------------------------------------------------
module ogih_back #(
    parameter int NUM_BINS  = 9,
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10,
    parameter int JOB_W     = 2 * ogih_pkg::D_W + AW + 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic [JOB_W-1:0] i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ogih_pkg::OUT_BINS-1:0][ogih_pkg::INT_W-1:0] o_bins,
    output logic [ogih_pkg::INT_W-1:0] o_mag,
    output logic             o_final,
    output logic             o_last
);
    localparam int IW = ogih_pkg::INT_W;
    localparam int SW = ogih_pkg::SUM_W;
    localparam int LW = (NUM_BINS + 1) * IW;
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_INIT = 2'd1;
    localparam logic [1:0] B_RUN  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [LW-1:0] mem_line [MAX_WIDTH];
    logic [LW-1:0] r_line;

    logic [1:0] r_state;
    logic [3:0] r_step;
    logic signed [ogih_pkg::D_W-1:0] r_dx, r_dy;
    logic r_set, r_top, r_final, r_last;
    logic [AW-1:0] r_col;
    logic [7:0]  r_ax;
    logic        r_xneg, r_xle0, r_ypos;
    logic [23:0] r_yy;
    logic [ogih_pkg::SQ_W-1:0] r_rem, r_res, r_bit;
    logic [ogih_pkg::BIN_W-1:0] r_cnt;
    logic [SW-1:0] r_rs [2][NUM_BINS];
    logic [SW-1:0] r_rm [2];
    logic r_ov;
    logic [NUM_BINS-1:0][IW-1:0] r_ob;
    logic [IW-1:0] r_om;
    logic r_of, r_ol;

    logic fire, neg, odd_add;
    logic signed [ogih_pkg::D_W-1:0] fx, fy;
    logic signed [17:0] sqx, sqy;
    logic [18:0] ssum;
    logic [ogih_pkg::SQ_W-1:0] trial;
    logic [26:0] prod;
    logic [1:0]  inc;
    logic [ogih_pkg::BIN_W-1:0] cnt_f, bin;
    logic [ogih_pkg::MAG_W-1:0] mag;
    logic [SW-1:0] ns [NUM_BINS];
    logic [SW-1:0] nm;
    logic [LW-1:0] wline;

    assign o_pop = (r_state == B_IDLE) && !i_empty;
    assign fire  = (r_state == B_OUT) && (!r_ov || !i_stall);

    always_comb begin
        neg  = (r_dy < 0) || (r_dy == 0 && r_dx < 0);
        fx   = neg ? -r_dx : r_dx;
        fy   = neg ? -r_dy : r_dy;
        sqx  = r_dx * r_dx;
        sqy  = r_dy * r_dy;
        ssum = {1'b0, unsigned'(sqx)} + {1'b0, unsigned'(sqy)};
        trial = r_res + r_bit;
        prod  = ogih_pkg::tan_of(NUM_BINS, r_step) * r_ax;
        inc   = 2'({1'b0, r_ypos && (r_xle0 || {3'b0, r_yy} >= prod)})
              + 2'({1'b0, r_xneg && {3'b0, r_yy} <= prod});
        odd_add = ((NUM_BINS % 2) != 0) && r_ypos && r_xle0;
        cnt_f = r_cnt + ogih_pkg::BIN_W'(odd_add);
        bin   = (cnt_f == '0) ? ogih_pkg::BIN_W'(NUM_BINS - 1) : cnt_f - 1'b1;
        mag   = r_res[ogih_pkg::MAG_W-1:0];
        // A new row starts its running sums from zero.
        for (int b = 0; b < NUM_BINS; b++) begin
            ns[b] = ((r_col == '0) ? '0 : r_rs[r_set][b])
                  + ((bin == ogih_pkg::BIN_W'(b)) ? SW'(mag) : '0);
            wline[b*IW +: IW] = (r_top ? '0 : r_line[b*IW +: IW]) + IW'(ns[b]);
        end
        nm = ((r_col == '0) ? '0 : r_rm[r_set]) + SW'(mag);
        wline[NUM_BINS*IW +: IW] = (r_top ? '0 : r_line[NUM_BINS*IW +: IW]) + IW'(nm);
    end

    always_ff @(posedge i_clk) begin
        r_line <= mem_line[r_col];
        if (fire) begin
            mem_line[r_col] <= wline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_dx, r_dy, r_set, r_top, r_col, r_final, r_last} <= i_job;
        end
        if (r_state == B_INIT) begin
            r_ax   <= (fx < 0) ? 8'(-fx) : 8'(fx);
            r_xneg <= (fx < 0);
            r_xle0 <= (fx <= 0);
            r_ypos <= (fy > 0);
            r_yy   <= {fy[7:0], 16'b0};
            r_rem  <= ogih_pkg::SQ_W'({ssum, 8'b0});
            r_res  <= '0;
            r_bit  <= ogih_pkg::SQ_W'(1) << 24;
            r_cnt  <= '0;
        end
        if (r_state == B_RUN) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_step < 4'(NUM_BINS / 2)) begin
                r_cnt <= r_cnt + ogih_pkg::BIN_W'(inc);
            end
        end
        if (fire) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                r_ob[b] <= wline[b*IW +: IW];
            end
            r_om <= wline[NUM_BINS*IW +: IW];
            r_of <= r_final;
            r_ol <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_step  <= '0;
            r_ov    <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_rm[s] <= '0;
                for (int b = 0; b < NUM_BINS; b++) r_rs[s][b] <= '0;
            end
        end else begin
            unique case (r_state)
                B_IDLE: if (o_pop) r_state <= B_INIT;
                B_INIT: begin
                    r_state <= B_RUN;
                    r_step  <= '0;
                end
                B_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'(ogih_pkg::SQ_STEPS - 1)) r_state <= B_OUT;
                end
                B_OUT: if (fire) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
            if (fire) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_restart) begin
                for (int s = 0; s < 2; s++) begin
                    r_rm[s] <= '0;
                    for (int b = 0; b < NUM_BINS; b++) r_rs[s][b] <= '0;
                end
            end else if (fire) begin
                r_rm[r_set] <= nm;
                for (int b = 0; b < NUM_BINS; b++) r_rs[r_set][b] <= ns[b];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < ogih_pkg::OUT_BINS; b++) begin
            o_bins[b] = (b < NUM_BINS) ? r_ob[b % NUM_BINS] : '0;
        end
    end
    assign o_valid = r_ov;
    assign o_mag   = r_om;
    assign o_final = r_of;
    assign o_last  = r_ol;

endmodule

/* tb/sv/oriented_gradient_integral_histogram_core_tb.sv */
// ---------------------------------------------------------------------------
// oriented_gradient_integral_histogram_core_tb
// Self-checking bench for the streaming gradient integral histogram core.
// ---------------------------------------------------------------------------
// A behavioral model of the core tracks the line buffers, row sums and
// integrals and queues the histogram results each pixel request causes.
// Every result leaving the core is compared field by field. The run covers
// the reset size, clamped and extreme image sizes, flat and high-contrast
// images, back-to-back images, images cut short by a size change, and
// random images with random idling on both sides.
// ---------------------------------------------------------------------------
module oriented_gradient_integral_histogram_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS      = 9;
    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic [NBINS-1:0][ogih_pkg::INT_W-1:0] hist;
        logic [ogih_pkg::INT_W-1:0]            mag;
        logic                                  fin;
        logic                                  last;
    } t_hist_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_index = ogih_pkg::CFG_WIDTH;
    logic [ogih_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic                         i_pixel_valid = 1'b0;
    logic                         o_pixel_stall;
    logic [ogih_pkg::PIX_W-1:0]   i_pixel = '0;
    logic                         o_result_valid;
    logic                         i_result_stall = 1'b0;
    logic [ogih_pkg::INT_W-1:0]   o_hist [NBINS];
    logic [ogih_pkg::INT_W-1:0]   o_magnitude_integral;
    logic                         o_final_row;
    logic                         o_last_of_run;

    oriented_gradient_integral_histogram_core u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_pixel_valid        (i_pixel_valid),
        .o_pixel_stall        (o_pixel_stall),
        .i_pixel              (i_pixel),
        .o_result_valid       (o_result_valid),
        .i_result_stall       (i_result_stall),
        .o_hist_bin0          (o_hist[0]),
        .o_hist_bin1          (o_hist[1]),
        .o_hist_bin2          (o_hist[2]),
        .o_hist_bin3          (o_hist[3]),
        .o_hist_bin4          (o_hist[4]),
        .o_hist_bin5          (o_hist[5]),
        .o_hist_bin6          (o_hist[6]),
        .o_hist_bin7          (o_hist[7]),
        .o_hist_bin8          (o_hist[8]),
        .o_magnitude_integral (o_magnitude_integral),
        .o_final_row          (o_final_row),
        .o_last_of_run        (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state.
    logic [ogih_pkg::CFG_W-1:0]  img_width_reg;
    logic [ogih_pkg::CFG_W-1:0]  img_height_reg;
    logic [ogih_pkg::PIX_W-1:0]  older_row [MAXW];
    logic [ogih_pkg::PIX_W-1:0]  newer_row [MAXW];
    logic [ogih_pkg::INT_W-1:0]  bin_line [MAXW][NBINS];
    logic [ogih_pkg::INT_W-1:0]  mag_line [MAXW];
    logic [ogih_pkg::SUM_W-1:0]  row_bin_acc [2][NBINS];
    logic [ogih_pkg::SUM_W-1:0]  row_mag_acc [2];
    int                          col_pos;
    int                          row_pos;

    t_hist_result      pending_hist_q [$];
    int                mismatch_count = 0;
    int                pixels_sent = 0;
    int                results_seen = 0;
    int                images_done = 0;
    bit                idle_on = 1'b0;

    function automatic int active_width();
        if (img_width_reg < 1) return 1;
        if (img_width_reg > MAXW) return MAXW;
        return int'(img_width_reg);
    endfunction

    function automatic int active_height();
        if (img_height_reg < 2) return 2;
        if (img_height_reg > MAXH) return MAXH;
        return int'(img_height_reg);
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // Orientation bin: folds the direction to the upper half plane and
    // counts boundaries crossed, using the 16-fraction-bit tangents.
    function automatic int orientation_bin(int dx, int dy);
        longint x, y, yy, t;
        int cnt;
        x = dx;
        y = dy;
        cnt = 0;
        if (y < 0 || (y == 0 && x < 0)) begin
            x = -x;
            y = -y;
        end
        yy = y * 65536;
        for (int i = 0; i < NBINS / 2; i++) begin
            t = longint'(ogih_pkg::TAN_TABLE[ogih_pkg::TAN_OFFSET[NBINS] + i]);
            if (y > 0 && (x <= 0 || yy >= t * x)) cnt++;
            if (x < 0 && yy <= t * (-x)) cnt++;
        end
        if ((NBINS % 2) == 1 && y > 0 && x <= 0) cnt++;
        return (cnt == 0) ? NBINS - 1 : cnt - 1;
    endfunction

    function automatic void queue_integral(int set, int row, int col, int dx, int dy,
                                           logic fin);
        t_hist_result res;
        logic [ogih_pkg::SUM_W-1:0] mag;
        logic [ogih_pkg::INT_W-1:0] above;
        int bin;
        if (col == 0) begin
            for (int b = 0; b < NBINS; b++) row_bin_acc[set][b] = '0;
            row_mag_acc[set] = '0;
        end
        mag = ogih_pkg::SUM_W'(floor_sqrt(longint'(dx * dx + dy * dy) * 256));
        bin = orientation_bin(dx, dy);
        row_bin_acc[set][bin] = row_bin_acc[set][bin] + mag;
        row_mag_acc[set] = row_mag_acc[set] + mag;
        for (int b = 0; b < NBINS; b++) begin
            above = (row == 0) ? '0 : bin_line[col][b];
            bin_line[col][b] = above + ogih_pkg::INT_W'(row_bin_acc[set][b]);
            res.hist[b] = bin_line[col][b];
        end
        above = (row == 0) ? '0 : mag_line[col];
        mag_line[col] = above + ogih_pkg::INT_W'(row_mag_acc[set]);
        res.mag = mag_line[col];
        res.fin = fin;
        res.last = 1'b0;
        pending_hist_q = {pending_hist_q, res};
    endfunction

    function automatic void last_row_gradient(int j, int w, output int dx, output int dy);
        int l, r;
        l = (j > 0) ? j - 1 : j;
        r = (j + 1 < w) ? j + 1 : j;
        dx = int'(newer_row[r]) - int'(newer_row[l]);
        dy = int'(newer_row[j]) - int'(older_row[j]);
    endfunction

    function automatic void predict_histogram(logic [ogih_pkg::PIX_W-1:0] pix);
        int w, h, c, r, a, lv, rv, pv, dx, dy, n;
        w = active_width();
        h = active_height();
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        n = 0;
        if (r == 0) begin
            newer_row[c] = pix;
        end else begin
            a  = int'(newer_row[c]);
            lv = (c > 0) ? int'(older_row[c-1]) : a;
            rv = (c + 1 < w) ? int'(newer_row[c+1]) : a;
            pv = (r == 1) ? a : int'(older_row[c]);
            older_row[c] = ogih_pkg::PIX_W'(a);
            newer_row[c] = pix;
            queue_integral(0, r - 1, c, rv - lv, int'(pix) - pv, 1'b0);
            n = 1;
            if (r == h - 1) begin
                if (c >= 1) begin
                    last_row_gradient(c - 1, w, dx, dy);
                    queue_integral(1, r, c - 1, dx, dy, 1'b1);
                    n++;
                end
                if (c == w - 1) begin
                    last_row_gradient(c, w, dx, dy);
                    queue_integral(1, r, c, dx, dy, 1'b1);
                    n++;
                end
            end
            pending_hist_q[pending_hist_q.size()-1].last = 1'b1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
                images_done++;
            end
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic void restart_image();
        col_pos = 0;
        row_pos = 0;
        for (int s = 0; s < 2; s++) begin
            for (int b = 0; b < NBINS; b++) row_bin_acc[s][b] = '0;
            row_mag_acc[s] = '0;
        end
    endfunction

    task automatic report(string what, logic [ogih_pkg::INT_W-1:0] got,
                          logic [ogih_pkg::INT_W-1:0] want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_hist_result want;
        if (i_rst_n && o_result_valid && !i_result_stall) begin
            results_seen++;
            if (pending_hist_q.size() == 0) begin
                report("unexpected result", o_magnitude_integral, '0);
            end else begin
                want = pending_hist_q.pop_front();
                for (int b = 0; b < NBINS; b++) begin
                    if (o_hist[b] !== want.hist[b])
                        report($sformatf("hist_bin%0d", b), o_hist[b], want.hist[b]);
                end
                if (o_magnitude_integral !== want.mag)
                    report("magnitude_integral", o_magnitude_integral, want.mag);
                if (o_final_row !== want.fin)
                    report("final_row", ogih_pkg::INT_W'(o_final_row),
                           ogih_pkg::INT_W'(want.fin));
                if (o_last_of_run !== want.last)
                    report("last_of_run", ogih_pkg::INT_W'(o_last_of_run),
                           ogih_pkg::INT_W'(want.last));
            end
        end
    end

    // Receiver stalls in random bursts.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_result_stall = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_result_stall = (stall_left != 0);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19);
            i_result_stall = 1'b1;
        end else begin
            i_result_stall = 1'b0;
        end
    end

    task automatic send_pixel(logic [ogih_pkg::PIX_W-1:0] pix);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_pixel_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_pixel_valid = 1'b1;
        i_pixel = pix;
        @(posedge i_clk);
        while (o_pixel_stall) @(posedge i_clk);
        predict_histogram(pix);
        pixels_sent++;
        @(negedge i_clk);
        i_pixel_valid = 1'b0;
    endtask

    // Waits for every queued result, then for the core's own pipeline to
    // empty, since pixels on row 0 leave no result to wait for.
    task automatic drain_results();
        i_pixel_valid = 1'b0;
        while (pending_hist_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_size(logic idx, logic [ogih_pkg::CFG_W-1:0] val);
        drain_results();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == ogih_pkg::CFG_WIDTH) img_width_reg = val;
        else img_height_reg = val;
        restart_image();
    endtask

    task automatic set_image(logic [ogih_pkg::CFG_W-1:0] w, logic [ogih_pkg::CFG_W-1:0] h);
        write_size(ogih_pkg::CFG_WIDTH, w);
        write_size(ogih_pkg::CFG_HEIGHT, h);
    endtask

    task automatic test_reset_size();
        // Reset size is 1024 wide, so these all land in row 0.
        for (int i = 0; i < 8; i++) send_pixel(ogih_pkg::PIX_W'(i * 37));
    endtask

    task automatic test_directed_images();
        set_image(11'd0, 11'd1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        set_image(11'd3, 11'd3);
        for (int i = 0; i < 9; i++) send_pixel(8'd128);
        for (int i = 0; i < 9; i++) send_pixel(((i % 2) == 1) ? 8'd255 : 8'd0);
        set_image(11'd2, 11'd2);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
    endtask

    task automatic test_size_extremes();
        set_image(11'd2047, 11'd2);
        for (int i = 0; i < 20; i++) send_pixel(ogih_pkg::PIX_W'($urandom));
        set_image(11'd3, 11'd2047);
        for (int i = 0; i < 12; i++) send_pixel(ogih_pkg::PIX_W'($urandom));
        set_image(11'd1024, 11'd1024);
        for (int i = 0; i < 6; i++) send_pixel(ogih_pkg::PIX_W'($urandom));
    endtask

    function automatic logic [ogih_pkg::PIX_W-1:0] random_pixel(int style, int idx);
        case (style)
            0: return ogih_pkg::PIX_W'($urandom);
            1: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            2: return ogih_pkg::PIX_W'(idx * 23);
            default: return 8'd200 + ogih_pkg::PIX_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic test_random_images(int count);
        int w, h, n_img, style, stop_at, start;
        start = pixels_sent;
        while (pixels_sent - start < count) begin
            if (pixels_sent - start > count - 90) idle_on = 1'b0;
            w = $urandom_range(1, 10);
            h = $urandom_range(2, 5);
            case ($urandom_range(0, 9))
                0: w = 0;
                1: h = $urandom_range(0, 1);
                2: w = 1;
                default: ;
            endcase
            set_image(ogih_pkg::CFG_W'(w), ogih_pkg::CFG_W'(h));
            w = active_width();
            h = active_height();
            n_img = $urandom_range(1, 2);
            style = $urandom_range(0, 3);
            stop_at = w * h * n_img;
            // Now and then the image is cut short by the next size change.
            if ($urandom_range(0, 5) == 0) stop_at = $urandom_range(1, stop_at);
            for (int i = 0; i < stop_at && pixels_sent - start < count; i++)
                send_pixel(random_pixel(style, i));
        end
    endtask

    initial begin
        img_width_reg = 11'd1024;
        img_height_reg = 11'd1024;
        restart_image();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_size();
        test_directed_images();
        idle_on = 1'b1;
        test_size_extremes();
        test_random_images(360);
        idle_on = 1'b0;
        drain_results();

        $display("Sent %0d pixels, checked %0d results, completed %0d images.",
                 pixels_sent, results_seen, images_done);
        $display("Sizes ranged from clamped minimum to maximum, with idling on both sides.");
        if (mismatch_count == 0 && pending_hist_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d results still pending.", pending_hist_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/ogih_pkg.sv
src/ogih_queue.sv
src/ogih_front.sv
src/ogih_back.sv
src/oriented_gradient_integral_histogram_core.sv
tb/sv/oriented_gradient_integral_histogram_core_tb.sv
